/* hdl/quaternion_log_rate_diff_assert.svh */
// Assertion macros for the quaternion log-map rate block.
// Used by the top level; needs nothing else.
`ifndef QUATERNION_LOG_RATE_DIFF_ASSERT_SVH
`define QUATERNION_LOG_RATE_DIFF_ASSERT_SVH

// same-cycle implication
`define QLRD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qlrd assertion failed");

// next-cycle implication
`define QLRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qlrd assertion failed");

`endif

/* hdl/qlrd_pkg.sv */
// Shared constants, types and tables for the quaternion log-map rate block.
// No dependencies.
package qlrd_pkg;

   localparam int QUAT_W           = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CNT_W            = 6;   // holds step counts up to 63
   localparam int ACC_W            = 33;
   localparam int MUL_W            = 33;
   localparam int PROD_W           = 2 * MUL_W;
   localparam int XY_W             = 36;
   localparam int Z_W              = 35;
   localparam int RATE_W           = 32;
   localparam int PROD_SH          = 2 * (QUAT_W - 1) - 28;  // component product to Q.28
   localparam int SMALL_U2_W       = 23;  // above this u2 can never be "small"
   localparam int LIM_SH           = 20;

   localparam logic [RATE_W-1:0] RATE_GAIN_RST = 32'd13107200;
   localparam logic [31:0]       ANG_PI        = 32'd3373259426;
   localparam logic [31:0]       ANG_HALF_PI   = 32'd1686629713;
   // 1e12 - 1 split as HI * 2^20 + LO
   localparam logic [19:0]       LIM_HI        = 20'd953674;
   localparam logic [19:0]       LIM_LO        = 20'd331775;

   localparam logic [1:0] CMP_X = 2'd0;
   localparam logic [1:0] CMP_Y = 2'd1;
   localparam logic [1:0] CMP_Z = 2'd2;
   localparam logic [1:0] CMP_W = 2'd3;

   typedef struct packed {
      logic [1:0] c_sel;
      logic [1:0] p_sel;
      logic       neg;
      logic [1:0] dst;
   } prod_op_type;

   // terms of cur * conj(prev), one per multiplier pass
   function automatic prod_op_type prod_op(input logic [3:0] i);
      prod_op_type op;
      case (i)
         4'd0:  op = '{CMP_W, CMP_W, 1'b0, CMP_W};
         4'd1:  op = '{CMP_X, CMP_X, 1'b0, CMP_W};
         4'd2:  op = '{CMP_Y, CMP_Y, 1'b0, CMP_W};
         4'd3:  op = '{CMP_Z, CMP_Z, 1'b0, CMP_W};
         4'd4:  op = '{CMP_X, CMP_W, 1'b0, CMP_X};
         4'd5:  op = '{CMP_W, CMP_X, 1'b1, CMP_X};
         4'd6:  op = '{CMP_Y, CMP_Z, 1'b1, CMP_X};
         4'd7:  op = '{CMP_Z, CMP_Y, 1'b0, CMP_X};
         4'd8:  op = '{CMP_Y, CMP_W, 1'b0, CMP_Y};
         4'd9:  op = '{CMP_W, CMP_Y, 1'b1, CMP_Y};
         4'd10: op = '{CMP_Z, CMP_X, 1'b1, CMP_Y};
         4'd11: op = '{CMP_X, CMP_Z, 1'b0, CMP_Y};
         4'd12: op = '{CMP_Z, CMP_W, 1'b0, CMP_Z};
         4'd13: op = '{CMP_W, CMP_Z, 1'b1, CMP_Z};
         4'd14: op = '{CMP_X, CMP_Y, 1'b1, CMP_Z};
         4'd15: op = '{CMP_Y, CMP_X, 1'b0, CMP_Z};
         default: op = '{CMP_W, CMP_W, 1'b0, CMP_W};
      endcase
      return op;
   endfunction

   // atan(2^-i) in Q.30, rounded to nearest
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd843314857;
         5'd1:  a = 32'd497837829;
         5'd2:  a = 32'd263043837;
         5'd3:  a = 32'd133525159;
         5'd4:  a = 32'd67021687;
         5'd5:  a = 32'd33543516;
         5'd6:  a = 32'd16775851;
         5'd7:  a = 32'd8388437;
         5'd8:  a = 32'd4194283;
         5'd9:  a = 32'd2097149;
         5'd31: a = 32'd1;
         default: a = 32'd1 << (5'd30 - i);
      endcase
      return a;
   endfunction

endpackage

/* hdl/qlrd_if.sv */
// Handshake channels of the quaternion log-map rate block.
// Depends on qlrd_pkg for widths.
interface qlrd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [qlrd_pkg::QUAT_W-1:0]  quat_x;
   logic signed [qlrd_pkg::QUAT_W-1:0]  quat_y;
   logic signed [qlrd_pkg::QUAT_W-1:0]  quat_z;
   logic signed [qlrd_pkg::QUAT_W-1:0]  quat_w;
   logic                                start_of_track;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, start_of_track,
                   input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, start_of_track,
                   output ready);
endinterface

interface qlrd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [qlrd_pkg::RATE_W-1:0]  rate_x;
   logic signed [qlrd_pkg::RATE_W-1:0]  rate_y;
   logic signed [qlrd_pkg::RATE_W-1:0]  rate_z;
   logic                                saturated;
   modport source (output valid, rate_x, rate_y, rate_z, saturated, input ready);
   modport sink   (input valid, rate_x, rate_y, rate_z, saturated, output ready);
endinterface

interface qlrd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [qlrd_pkg::RATE_W-1:0]  rate_gain;
   modport source (output valid, rate_gain, input ready);
   modport sink   (input valid, rate_gain, output ready);
endinterface

/* hdl/quaternion_log_rate_diff.sv */
// Steps per sample: quaternion product, squares, limit check, sqrt, CORDIC_STEPS angle
// steps, divide and gain scale per axis, output register. The limit check is skipped
// when u2 >= 2^23; a zero vector part ends there, a small one after it. A new sample is
// taken only once the last result is in the output register; one shared multiplier and
// bit-serial sqrt and divide serve every step. Reset (synchronous, active high) clears
// the previous quaternion to zero, sets rate_gain to 200.0, empties the result register.
`include "quaternion_log_rate_diff_assert.svh"

module quaternion_log_rate_diff #(
   parameter int CORDIC_STEPS = qlrd_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   qlrd_req_if.sink    req_bus,
   qlrd_rsp_if.source  rsp_bus,
   qlrd_csr_if.sink    csr_bus
);

   localparam int QW  = qlrd_pkg::QUAT_W;
   localparam int AW  = qlrd_pkg::ACC_W;
   localparam int MW  = qlrd_pkg::MUL_W;
   localparam int PW  = qlrd_pkg::PROD_W;
   localparam int XW  = qlrd_pkg::XY_W;
   localparam int ZW  = qlrd_pkg::Z_W;
   localparam int RW  = qlrd_pkg::RATE_W;
   localparam int CW  = qlrd_pkg::CNT_W;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_PROD   = 15'b000000000000010,
      S_PACC   = 15'b000000000000100,
      S_SQ     = 15'b000000000001000,
      S_SQACC  = 15'b000000000010000,
      S_LIM    = 15'b000000000100000,
      S_LIMACC = 15'b000000001000000,
      S_SQRT   = 15'b000000010000000,
      S_CORDIC = 15'b000000100000000,
      S_CMUL   = 15'b000001000000000,
      S_CMACC  = 15'b000010000000000,
      S_DIV    = 15'b000100000000000,
      S_GMUL   = 15'b001000000000000,
      S_GACC   = 15'b010000000000000,
      S_DONE   = 15'b100000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [QW-1:0]    prev_ff [4];
   logic signed [QW-1:0]    prev_in [4];
   logic signed [QW-1:0]    c_ff [4];
   logic signed [QW-1:0]    c_in [4];
   logic signed [QW-1:0]    p_ff [4];
   logic signed [QW-1:0]    p_in [4];
   logic signed [AW-1:0]    acc_ff [4];
   logic signed [AW-1:0]    acc_in [4];
   logic [63:0]             u2_ff, u2_in;
   logic [63:0]             w2_ff, w2_in;
   logic [63:0]             lim_ff, lim_in;
   logic [63:0]             rem_ff, rem_in;
   logic [63:0]             root_ff, root_in;
   logic [63:0]             sbit_ff, sbit_in;
   logic [31:0]             m_ff, m_in;
   logic signed [XW-1:0]    x_ff, x_in;
   logic signed [XW-1:0]    y_ff, y_in;
   logic signed [ZW-1:0]    z_ff, z_in;
   logic [31:0]             dvd_ff, dvd_in;
   logic [31:0]             quo_ff, quo_in;
   logic [1:0]              kidx_ff, kidx_in;
   logic [RW-1:0]           res_ff [3];
   logic [RW-1:0]           res_in [3];
   logic                    sat_ff, sat_in;
   logic [RW-1:0]           gain_ff, gain_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [RW-1:0]           rsp_x_ff, rsp_x_in;
   logic [RW-1:0]           rsp_y_ff, rsp_y_in;
   logic [RW-1:0]           rsp_z_ff, rsp_z_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic                    mul_en;
   logic signed [MW-1:0]    op_a, op_b;
   logic signed [PW-1:0]    prod_ff;
   qlrd_pkg::prod_op_type   pop;
   logic signed [AW-1:0]    kacc;
   logic signed [AW-1:0]    kmag;
   logic [31:0]             ang;
   logic signed [ZW-1:0]    pi_z;

   // working variables of the sequencer
   logic signed [PW-1:0]    shp;
   logic signed [AW-1:0]    term;
   logic [63:0]             sq;
   logic [63:0]             tot;
   logic [63:0]             trial;
   logic signed [XW-1:0]    dx, dy;
   logic signed [ZW-1:0]    za;
   logic [32:0]             r2;
   logic [63:0]             rnd;
   logic [33:0]             rmag;
   logic signed [AW-1:0]    w_cur;

   qlrd_mul u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.rate_x    = rsp_x_ff;
   assign rsp_bus.rate_y    = rsp_y_ff;
   assign rsp_bus.rate_z    = rsp_z_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

   assign pop   = qlrd_pkg::prod_op(cnt_ff[3:0]);
   assign kacc  = acc_ff[kidx_ff];
   assign kmag  = kacc[AW-1] ? -kacc : kacc;
   assign w_cur = acc_ff[qlrd_pkg::CMP_W];
   assign pi_z  = $signed(ZW'(qlrd_pkg::ANG_PI));

   // clamp the CORDIC angle to [0, pi]
   always_comb begin
      if (z_ff[ZW-1]) begin
         ang = '0;
      end else if (z_ff > pi_z) begin
         ang = qlrd_pkg::ANG_PI;
      end else begin
         ang = z_ff[31:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      mul_en = 1'b0;
      case (state_ff)
         S_PROD: begin
            op_a   = MW'(c_ff[pop.c_sel]);
            op_b   = MW'(p_ff[pop.p_sel]);
            mul_en = 1'b1;
         end
         S_SQ: begin
            op_a   = MW'(acc_ff[cnt_ff[1:0]]);
            op_b   = MW'(acc_ff[cnt_ff[1:0]]);
            mul_en = 1'b1;
         end
         S_LIM: begin
            op_a   = $signed(MW'(u2_ff[qlrd_pkg::SMALL_U2_W-1:0]));
            op_b   = $signed(MW'(cnt_ff[0] ? qlrd_pkg::LIM_LO : qlrd_pkg::LIM_HI));
            mul_en = 1'b1;
         end
         S_CMUL: begin
            op_a   = $signed(MW'(ang));
            op_b   = MW'(kmag);
            mul_en = 1'b1;
         end
         S_GMUL: begin
            op_a   = $signed(MW'(quo_ff));
            op_b   = $signed(MW'(gain_ff));
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      prev_in    = prev_ff;
      c_in       = c_ff;
      p_in       = p_ff;
      acc_in     = acc_ff;
      u2_in      = u2_ff;
      w2_in      = w2_ff;
      lim_in     = lim_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      sbit_in    = sbit_ff;
      m_in       = m_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      kidx_in    = kidx_ff;
      res_in     = res_ff;
      sat_in     = sat_ff;
      gain_in    = gain_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_bus.ready;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_z_in   = rsp_z_ff;
      rsp_sat_in = rsp_sat_ff;
      shp        = '0;
      term       = '0;
      sq         = '0;
      tot        = '0;
      trial      = '0;
      dx         = '0;
      dy         = '0;
      za         = '0;
      r2         = '0;
      rnd        = '0;
      rmag       = '0;

      if (csr_bus.valid) begin
         gain_in = csr_bus.rate_gain;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               c_in[qlrd_pkg::CMP_X] = req_bus.quat_x;
               c_in[qlrd_pkg::CMP_Y] = req_bus.quat_y;
               c_in[qlrd_pkg::CMP_Z] = req_bus.quat_z;
               c_in[qlrd_pkg::CMP_W] = req_bus.quat_w;
               if (req_bus.start_of_track) begin
                  p_in = c_in;
               end else begin
                  p_in = prev_ff;
               end
               prev_in = c_in;
               for (int k = 0; k < 4; k++) begin
                  acc_in[k] = '0;
               end
               for (int k = 0; k < 3; k++) begin
                  res_in[k] = '0;
               end
               u2_in    = '0;
               sat_in   = 1'b0;
               cnt_in   = '0;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            state_in = S_PACC;
         end
         S_PACC: begin
            shp  = prod_ff >>> qlrd_pkg::PROD_SH;
            term = AW'(shp);
            acc_in[pop.dst] = pop.neg ? acc_ff[pop.dst] - term : acc_ff[pop.dst] + term;
            if (cnt_ff == CW'(15)) begin
               cnt_in   = '0;
               state_in = S_SQ;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_PROD;
            end
         end
         S_SQ: begin
            state_in = S_SQACC;
         end
         S_SQACC: begin
            sq = prod_ff[63:0];
            if (cnt_ff[1:0] == qlrd_pkg::CMP_W) begin
               w2_in    = sq;
               cnt_in   = '0;
               state_in = S_LIM;
            end else begin
               u2_in    = u2_ff + sq;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SQ;
            end
         end
         S_LIM: begin
            if (u2_ff == '0) begin
               state_in = S_DONE;
            end else if (u2_ff[63:qlrd_pkg::SMALL_U2_W] != '0) begin
               rem_in   = u2_ff;
               root_in  = '0;
               sbit_in  = 64'd1 << 62;
               state_in = S_SQRT;
            end else begin
               state_in = S_LIMACC;
            end
         end
         S_LIMACC: begin
            if (cnt_ff[0] == 1'b0) begin
               lim_in   = prod_ff[63:0] << qlrd_pkg::LIM_SH;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_LIM;
            end else begin
               // u2 * (1e12 - 1) < w2 means the vector part is negligible
               tot = lim_ff + prod_ff[63:0];
               if (tot < w2_ff) begin
                  state_in = S_DONE;
               end else begin
                  rem_in   = u2_ff;
                  root_in  = '0;
                  sbit_in  = 64'd1 << 62;
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            trial = root_ff + sbit_ff;
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + sbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               m_in   = root_in[31:0];
               cnt_in = '0;
               if (w_cur[AW-1]) begin
                  x_in = XW'({1'b0, root_in[31:0]});
                  y_in = -XW'(w_cur);
                  z_in = $signed(ZW'(qlrd_pkg::ANG_HALF_PI));
               end else begin
                  x_in = XW'(w_cur);
                  y_in = XW'({1'b0, root_in[31:0]});
                  z_in = '0;
               end
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            dx = y_ff >>> cnt_ff;
            dy = x_ff >>> cnt_ff;
            za = $signed(ZW'(qlrd_pkg::atan_q30(cnt_ff[4:0])));
            if (y_ff > 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + za;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - za;
            end
            if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
               kidx_in  = '0;
               state_in = S_CMUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CMUL: begin
            state_in = S_CMACC;
         end
         S_CMACC: begin
            // high half is below m since the quotient stays under 2^32
            rem_in   = {32'd0, prod_ff[63:32]};
            dvd_in   = prod_ff[31:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            r2     = {rem_ff[31:0], dvd_ff[31]};
            dvd_in = dvd_ff << 1;
            if (r2 >= {1'b0, m_ff}) begin
               rem_in = 64'(r2 - {1'b0, m_ff});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = 64'(r2);
               quo_in = {quo_ff[30:0], 1'b0};
            end
            if (cnt_ff == CW'(31)) begin
               state_in = S_GMUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_GMUL: begin
            state_in = S_GACC;
         end
         S_GACC: begin
            rnd  = prod_ff[63:0] + (64'd1 << 29);
            rmag = rnd[63:30];
            if (kacc[AW-1]) begin
               if (rmag > 34'h0_8000_0000) begin
                  res_in[kidx_ff] = 32'h8000_0000;
                  sat_in          = 1'b1;
               end else begin
                  res_in[kidx_ff] = 32'd0 - rmag[31:0];
               end
            end else begin
               if (rmag > 34'h0_7FFF_FFFF) begin
                  res_in[kidx_ff] = 32'h7FFF_FFFF;
                  sat_in          = 1'b1;
               end else begin
                  res_in[kidx_ff] = rmag[31:0];
               end
            end
            if (kidx_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               kidx_in  = kidx_ff + 1'b1;
               state_in = S_CMUL;
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in = 1'b1;
               rsp_x_in   = res_ff[0];
               rsp_y_in   = res_ff[1];
               rsp_z_in   = res_ff[2];
               rsp_sat_in = sat_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         gain_ff    <= qlrd_pkg::RATE_GAIN_RST;
         for (int k = 0; k < 4; k++) begin
            prev_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         gain_ff    <= gain_in;
         prev_ff    <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff       <= c_in;
      p_ff       <= p_in;
      acc_ff     <= acc_in;
      u2_ff      <= u2_in;
      w2_ff      <= w2_in;
      lim_ff     <= lim_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      sbit_ff    <= sbit_in;
      m_ff       <= m_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      kidx_ff    <= kidx_in;
      res_ff     <= res_in;
      sat_ff     <= sat_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   `QLRD_ASSERT_IMPL(a_div_rem, clock, reset, state_ff == S_DIV,
      (rem_ff[63:32] == '0) && (rem_ff[31:0] < m_ff))
   `QLRD_ASSERT_IMPL(a_cordic_cnt, clock, reset, state_ff == S_CORDIC,
      cnt_ff < CW'(CORDIC_STEPS))
   `QLRD_ASSERT_NEXT(a_accept_start, clock, reset, req_bus.valid && req_bus.ready,
      (state_ff == S_PROD) && (cnt_ff == '0))
   `QLRD_ASSERT_IMPL(a_zero_vec, clock, reset, (state_ff == S_DONE) && (u2_ff == '0),
      (res_ff[0] == '0) && (res_ff[1] == '0) && (res_ff[2] == '0) && !sat_ff)

endmodule

/* hdl/qlrd_mul.sv */
// Shared signed multiplier with registered product.
// Depends on qlrd_pkg for operand widths.
module qlrd_mul (
   input  logic                                 clock,
   input  logic                                 mul_en,
   input  logic signed [qlrd_pkg::MUL_W-1:0]    op_a,
   input  logic signed [qlrd_pkg::MUL_W-1:0]    op_b,
   output logic signed [qlrd_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [qlrd_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = qlrd_pkg::PROD_W'(op_a) * qlrd_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule
